// File: sv/psfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfr_pkg
// Shared types and constants of the particle sensor frame receiver: result
// codes, register indexes, reset values and the controller/datapath link.
// ----------------------------------------------------------------------------
package psfr_pkg;

   typedef logic [1:0] status_type;

   // Result codes
   localparam status_type ST_VALID      = 2'd0;
   localparam status_type ST_BAD_HEADER = 2'd1;
   localparam status_type ST_BAD_SUM    = 2'd2;

   // Configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type REG_HEADER_FIRST  = 2'd0;
   localparam csr_index_type REG_HEADER_SECOND = 2'd1;

   // Register reset values
   localparam logic [7:0] HEADER_FIRST_RESET  = 8'h42;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'h4D;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;      // byte transfer: store it at the fill position
      logic scan_start;  // frame complete: rewind the read address
      logic rd_step;     // issue one store read, advance the read address
      logic copy_mode;   // returned read data is moved down, not checked
      logic load_rsp;    // capture the check outcome in the result register
      logic copy_start;  // begin realignment at the header pair found
      logic clear_fill;  // empty the store
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_slot;   // next byte completes the frame
      logic rd_last;     // read address is at the last store entry
      logic frame_ok;    // header and checksum both match
      logic hit_found;   // a later header pair was seen during the scan
   } sts_type;

endpackage
`default_nettype wire

// File: sv/psfr_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfr_dpath
// Frame store, fill count, scan accumulators, header registers, realignment
// copy and the result register.
// ----------------------------------------------------------------------------
module psfr_dpath #(
   parameter int FRAME_LEN = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire psfr_pkg::cmd_type      cmd,
   output psfr_pkg::sts_type           sts,
   input  wire logic [7:0]             rx_byte,
   input  wire logic                   csr_we,
   input  wire psfr_pkg::csr_index_type csr_index,
   input  wire logic [7:0]             csr_wdata,
   output psfr_pkg::status_type        rsp_status,
   output logic [15:0]                 rsp_pm_1um,
   output logic [15:0]                 rsp_pm_2p5um,
   output logic [15:0]                 rsp_pm_10um
);

   localparam int AW = $clog2(FRAME_LEN);
   localparam logic [AW-1:0] IDX_LAST   = AW'(FRAME_LEN - 1);
   localparam logic [AW-1:0] IDX_TRL_HI = AW'(FRAME_LEN - 2);
   localparam logic [AW-1:0] IDX_SUM_END = AW'(FRAME_LEN - 3);
   localparam logic [AW:0]   LEN_W      = (AW+1)'(FRAME_LEN);

   logic [7:0]    mem [FRAME_LEN];

   logic [7:0]    hdr_first_ff, hdr_second_ff;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [AW-1:0] cp_dst_ff;
   logic [7:0]    rd_data_ff;
   logic          dv_ff;
   logic [AW-1:0] didx_ff;
   logic [7:0]    b0_ff, b1_ff, prev_ff;
   logic [15:0]   sum_ff, trail_ff;
   logic [15:0]   pa_ff, pb_ff, pc_ff;
   logic          hit_ff;
   logic [AW-1:0] hit_off_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          hdr_ok, sum_ok, scan_en;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= psfr_pkg::HEADER_FIRST_RESET;
         hdr_second_ff <= psfr_pkg::HEADER_SECOND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            psfr_pkg::REG_HEADER_FIRST:  hdr_first_ff  <= csr_wdata;
            psfr_pkg::REG_HEADER_SECOND: hdr_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Store write port: incoming byte or realignment copy
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff;
      wr_data = rx_byte;
      if (cmd.accept) begin
         wr_en = 1'b1;
      end else if (dv_ff && cmd.copy_mode) begin
         wr_en   = 1'b1;
         wr_addr = cp_dst_ff;
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   // Fill count and read address
   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear_fill) begin
         fill_in = '0;
      end else if (cmd.copy_start) begin
         fill_in = AW'(LEN_W - {1'b0, hit_off_ff});
      end else if (cmd.accept && !sts.last_slot) begin
         fill_in = fill_ff + 1'b1;
      end

      rd_addr_in = rd_addr_ff;
      if (cmd.scan_start) begin
         rd_addr_in = '0;
      end else if (cmd.copy_start) begin
         rd_addr_in = hit_off_ff;
      end else if (cmd.rd_step) begin
         rd_addr_in = rd_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         dv_ff   <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         dv_ff   <= cmd.rd_step;
      end
      rd_addr_ff <= rd_addr_in;
      didx_ff    <= rd_addr_ff;
      if (cmd.copy_start) begin
         cp_dst_ff <= '0;
      end else if (dv_ff && cmd.copy_mode) begin
         cp_dst_ff <= cp_dst_ff + 1'b1;
      end
   end

   // Scan: header bytes, checksum, trailer, readings and header pair search
   assign scan_en = dv_ff && !cmd.copy_mode;

   always_ff @(posedge clock) begin
      if (scan_en) begin
         prev_ff <= rd_data_ff;
         if (didx_ff == '0) begin
            b0_ff  <= rd_data_ff;
            sum_ff <= {8'h00, rd_data_ff};
            hit_ff <= 1'b0;
         end else begin
            if (didx_ff <= IDX_SUM_END) begin
               sum_ff <= sum_ff + {8'h00, rd_data_ff};
            end
            if (didx_ff != AW'(1) && !hit_ff && prev_ff == hdr_first_ff
                && rd_data_ff == hdr_second_ff) begin
               hit_ff     <= 1'b1;
               hit_off_ff <= didx_ff - 1'b1;
            end
         end
         if (didx_ff == AW'(1)) b1_ff <= rd_data_ff;
         if (didx_ff == AW'(4)) pa_ff[15:8] <= rd_data_ff;
         if (didx_ff == AW'(5)) pa_ff[7:0]  <= rd_data_ff;
         if (didx_ff == AW'(6)) pb_ff[15:8] <= rd_data_ff;
         if (didx_ff == AW'(7)) pb_ff[7:0]  <= rd_data_ff;
         if (didx_ff == AW'(8)) pc_ff[15:8] <= rd_data_ff;
         if (didx_ff == AW'(9)) pc_ff[7:0]  <= rd_data_ff;
         if (didx_ff == IDX_TRL_HI) trail_ff[15:8] <= rd_data_ff;
         if (didx_ff == IDX_LAST)   trail_ff[7:0]  <= rd_data_ff;
      end
   end

   assign hdr_ok = (b0_ff == hdr_first_ff) && (b1_ff == hdr_second_ff);
   assign sum_ok = (sum_ff == trail_ff);

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (!hdr_ok) begin
            rsp_status <= psfr_pkg::ST_BAD_HEADER;
         end else if (!sum_ok) begin
            rsp_status <= psfr_pkg::ST_BAD_SUM;
         end else begin
            rsp_status <= psfr_pkg::ST_VALID;
         end
         rsp_pm_1um   <= (hdr_ok && sum_ok) ? pa_ff : 16'h0000;
         rsp_pm_2p5um <= (hdr_ok && sum_ok) ? pb_ff : 16'h0000;
         rsp_pm_10um  <= (hdr_ok && sum_ok) ? pc_ff : 16'h0000;
      end
   end

   assign sts.last_slot = (fill_ff == IDX_LAST);
   assign sts.rd_last   = (rd_addr_ff == IDX_LAST);
   assign sts.frame_ok  = hdr_ok && sum_ok;
   assign sts.hit_found = hit_ff;

endmodule
`default_nettype wire

// File: sv/psfr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfr_ctrl
// Sequencer of the frame receiver: byte intake, frame scan, result hand-off
// and realignment copy. Owns the result valid flag.
// ----------------------------------------------------------------------------
module psfr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire psfr_pkg::sts_type sts,
   output psfr_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_TAIL,
      S_POST,
      S_COPY,
      S_COPY_TAIL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands and next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && sts.last_slot) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_step = 1'b1;
            if (sts.rd_last) state_in = S_SCAN_TAIL;
         end
         S_SCAN_TAIL: begin
            state_in = S_POST;
         end
         S_POST: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               if (!sts.frame_ok && sts.hit_found) begin
                  cmd.copy_start = 1'b1;
                  state_in       = S_COPY;
               end else begin
                  cmd.clear_fill = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         S_COPY: begin
            cmd.rd_step   = 1'b1;
            cmd.copy_mode = 1'b1;
            if (sts.rd_last) state_in = S_COPY_TAIL;
         end
         S_COPY_TAIL: begin
            cmd.copy_mode = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/particle_sensor_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// particle_sensor_frame_receiver
// Collects sensor bytes into a frame, checks header and checksum, returns
// the three particle readings or a failure code, and realigns on failure.
// ----------------------------------------------------------------------------
// A byte that does not complete a frame is stored and the block is ready
// again at once. The byte that completes a frame starts a walk over the
// frame store through its single registered read port, followed by any
// wait for the previous result to be taken. On a failure with a later
// header pair at offset i, the kept bytes are moved down one per cycle.
// Input is not taken during the walk or the move; a finished result waits
// in the output register while new bytes are taken. Header bytes are
// written through csr_we/csr_index.
module particle_sensor_frame_receiver #(
   parameter int FRAME_LEN = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_rx_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output psfr_pkg::status_type         rsp_status,
   output logic [15:0]                  rsp_pm_1um,
   output logic [15:0]                  rsp_pm_2p5um,
   output logic [15:0]                  rsp_pm_10um,
   input  wire logic                    csr_we,
   input  wire psfr_pkg::csr_index_type csr_index,
   input  wire logic [7:0]              csr_wdata
);

   psfr_pkg::cmd_type cmd;
   psfr_pkg::sts_type sts;

   psfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   psfr_dpath #(
      .FRAME_LEN (FRAME_LEN)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .rx_byte      (req_rx_byte),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_status   (rsp_status),
      .rsp_pm_1um   (rsp_pm_1um),
      .rsp_pm_2p5um (rsp_pm_2p5um),
      .rsp_pm_10um  (rsp_pm_10um)
   );

   // Frame-completing transfer starts the scan and closes the input
   a_scan_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && sts.last_slot) |=> !req_ready)
      else $error("input still open after frame completed");

   // A result is only loaded into a free output register
   a_load_free_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending result");

   // Result valid only rises after a load
   a_valid_from_load : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_rsp))
      else $error("result valid without a load");

endmodule
`default_nettype wire
